FILE: rtl/i2c_master_bit_sequencer_macros.svh
// assertion macros shared by the bit sequencer rtl
// expects clk and arst_n to exist in the module that uses them
`ifndef I2C_MASTER_BIT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_MACROS_SVH

// same-cycle implication, held off while in reset
`define I2CBS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2cbs assertion failed");

// next-cycle implication, held off while in reset
`define I2CBS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2cbs assertion failed");

`endif

FILE: rtl/i2cbs_pkg.sv
// shared types, command codes and the phase table of the bit sequencer
// no dependencies
package i2cbs_pkg;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_STOP  = 2'd3;

	localparam int QUEUE_DEPTH = 2;
	localparam logic [7:0] PHASE_LENGTH_RST = 8'd7;

	localparam int IDX_W = 5;
	localparam logic [IDX_W-1:0] LAST_IDX_SHORT = 5'd2;
	localparam logic [IDX_W-1:0] LAST_IDX_BYTE  = 5'd18;
	localparam logic [IDX_W-1:0] ACK_LO_IDX     = 5'd16;
	localparam logic [IDX_W-1:0] ACK_HI_IDX     = 5'd17;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       data;
		logic             nack;
		logic [IDX_W-1:0] last_idx;
	} cmd_desc_t;

	typedef struct packed {
		logic       scl;
		logic       drv;
		logic       sda;
		logic [7:0] rx;
		logic       last;
	} phase_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// line levels of phase idx of a command
	function automatic phase_t phase_of(cmd_desc_t d, logic [IDX_W-1:0] idx);
		phase_t p;
		logic [7:0] sh;
		p = '0;
		sh = d.data << idx[3:1];
		p.last = (idx == d.last_idx);
		case (d.kind)
			CMD_START: begin
				p.drv = 1'b1;
				p.scl = (idx != LAST_IDX_SHORT);
				p.sda = (idx == '0);
			end
			CMD_WRITE: begin
				if (!idx[4]) begin
					p.scl = idx[0];
					p.drv = 1'b1;
					p.sda = sh[7];
				end else if (idx == ACK_LO_IDX || idx == ACK_HI_IDX) begin
					p.scl = (idx == ACK_HI_IDX);
					p.sda = 1'b1;
				end else begin
					p.drv = 1'b1;
				end
			end
			CMD_READ: begin
				if (!idx[4]) begin
					p.scl = idx[0];
					p.sda = 1'b1;
				end else if (idx == ACK_LO_IDX || idx == ACK_HI_IDX) begin
					p.scl = (idx == ACK_HI_IDX);
					p.drv = 1'b1;
					p.sda = d.nack;
				end else begin
					p.drv = 1'b1;
					p.sda = 1'b1;
					p.rx  = d.data;
				end
			end
			default: begin
				p.scl = (idx != '0);
				p.drv = (idx != LAST_IDX_SHORT);
				p.sda = (idx == LAST_IDX_SHORT);
			end
		endcase
		return p;
	endfunction

endpackage

FILE: rtl/i2cbs_if.sv
// request and line phase channels of the bit sequencer
// no dependencies
interface i2cbs_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] tx_byte;
	logic       send_nack;
	logic [7:0] bus_levels;

	modport source (output valid, func, tx_byte, send_nack, bus_levels, input ready);
	modport sink (input valid, func, tx_byte, send_nack, bus_levels, output ready);
endinterface

interface i2cbs_phase_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_driven;
	logic       sda_level;
	logic [7:0] rx_byte;
	logic       last_phase;

	modport source (output valid, scl_level, sda_driven, sda_level, rx_byte, last_phase,
		input ready);
	modport sink (input valid, scl_level, sda_driven, sda_level, rx_byte, last_phase,
		output ready);
endinterface

FILE: rtl/i2cbs_front.sv
// front end: takes requests, classifies them and pushes a descriptor
// depends on i2cbs_pkg and i2cbs_if
module i2cbs_front (
	input  logic                  clk,
	input  logic                  arst_n,
	i2cbs_cmd_if.sink             cmd,
	input  i2cbs_pkg::q_stat_t    q_stat,
	output logic                  push,
	output i2cbs_pkg::cmd_desc_t  push_desc
);

	logic                 valid_s1;
	i2cbs_pkg::cmd_desc_t desc_s1;
	i2cbs_pkg::cmd_desc_t desc_new;
	logic                 accept;
	logic                 is_byte;

	assign push      = valid_s1 && !q_stat.full;
	assign push_desc = desc_s1;
	assign cmd.ready = !valid_s1 || !q_stat.full;
	assign accept    = cmd.valid && cmd.ready;

	// a read carries the sampled levels, they form the received byte directly
	assign is_byte = (cmd.func == i2cbs_pkg::CMD_WRITE) || (cmd.func == i2cbs_pkg::CMD_READ);

	always_comb begin
		desc_new.kind     = cmd.func;
		desc_new.data     = (cmd.func == i2cbs_pkg::CMD_READ) ? cmd.bus_levels : cmd.tx_byte;
		desc_new.nack     = cmd.send_nack;
		desc_new.last_idx = is_byte ? i2cbs_pkg::LAST_IDX_BYTE : i2cbs_pkg::LAST_IDX_SHORT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc_new;
		end
	end

endmodule

FILE: rtl/i2cbs_queue.sv
// short descriptor queue between front and back end
// depends on i2cbs_pkg
module i2cbs_queue #(
	parameter int Depth = i2cbs_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  i2cbs_pkg::cmd_desc_t  push_desc,
	input  logic                  pop,
	output i2cbs_pkg::cmd_desc_t  pop_desc,
	output i2cbs_pkg::q_stat_t    q_stat
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	i2cbs_pkg::cmd_desc_t slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign q_stat.full  = (cnt_q == CntFull);
	assign q_stat.empty = (cnt_q == '0);
	assign pop_desc     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

FILE: rtl/i2cbs_back.sv
// back end: walks the line phases of one descriptor and paces them
// depends on i2cbs_pkg, i2cbs_if and the assertion macro header
`include "i2c_master_bit_sequencer_macros.svh"

module i2cbs_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            phase_length,
	input  i2cbs_pkg::q_stat_t    q_stat,
	input  i2cbs_pkg::cmd_desc_t  pop_desc,
	output logic                  pop,
	i2cbs_phase_if.source         phase
);

	logic                          busy_q;
	i2cbs_pkg::cmd_desc_t          desc_q;
	logic [i2cbs_pkg::IDX_W-1:0]   idx_q;
	logic [7:0]                    tick_q;
	logic                          out_valid_q;
	i2cbs_pkg::phase_t             out_q;
	i2cbs_pkg::phase_t             cur;
	logic                          tick_done;
	logic                          slot_free;
	logic                          load;

	assign pop       = !busy_q && !q_stat.empty;
	assign tick_done = ({1'b0, tick_q} + 9'd1) >= {1'b0, phase_length};
	assign slot_free = !out_valid_q || phase.ready;
	assign load      = busy_q && tick_done && slot_free;
	assign cur       = i2cbs_pkg::phase_of(desc_q, idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				tick_q <= '0;
			end else if (load) begin
				tick_q <= '0;
				if (cur.last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end else if (busy_q && !tick_done) begin
				tick_q <= tick_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (phase.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= pop_desc;
		end
		if (load) begin
			out_q <= cur;
		end
	end

	assign phase.valid      = out_valid_q;
	assign phase.scl_level  = out_q.scl;
	assign phase.sda_driven = out_q.drv;
	assign phase.sda_level  = out_q.sda;
	assign phase.rx_byte    = out_q.rx;
	assign phase.last_phase = out_q.last;

	`I2CBS_ASSERT_NEXT(a_last_frees, load && cur.last, !busy_q)
	`I2CBS_ASSERT_IMPL(a_idx_bound, busy_q, idx_q <= desc_q.last_idx)
	`I2CBS_ASSERT_IMPL(a_rx_only_last, out_valid_q && !out_q.last, out_q.rx == '0)
	`I2CBS_ASSERT_NEXT(a_pop_starts, pop, busy_q && idx_q == '0 && tick_q == '0)

endmodule

FILE: rtl/i2c_master_bit_sequencer.sv
// i2c master bit sequencer top level: front end, descriptor queue, back end
// a taken request passes the front end register and the descriptor queue before an idle
// back end pops it; the back end tick counter then paces each phase by phase_length
// a byte request walks 19 line phases, a start or stop 3; a phase not yet taken holds the walk
// reset: arst_n clears all control state and sets phase_length to 7
module i2c_master_bit_sequencer #(
	parameter int QueueDepth = i2cbs_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [7:0]    cfg_wr_data,
	i2cbs_cmd_if.sink     cmd,
	i2cbs_phase_if.source phase
);

	// phase length register, only paces the phases and never changes a result
	logic [7:0] phase_length_q;

	// front to queue
	logic                 push;
	i2cbs_pkg::cmd_desc_t push_desc;

	// queue to back end
	logic                 pop;
	i2cbs_pkg::cmd_desc_t pop_desc;
	i2cbs_pkg::q_stat_t   q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_length_q <= i2cbs_pkg::PHASE_LENGTH_RST;
		end else if (cfg_wr_en) begin
			phase_length_q <= cfg_wr_data;
		end
	end

	// request intake and classification, stalls only when the queue is full
	i2cbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.q_stat    (q_stat),
		.push      (push),
		.push_desc (push_desc)
	);

	// decouples intake from the slow line phase walk
	i2cbs_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.pop_desc  (pop_desc),
		.q_stat    (q_stat)
	);

	// phase walk with its own output register; a held phase stalls the walk and, once the queue fills, intake
	i2cbs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.phase_length (phase_length_q),
		.q_stat       (q_stat),
		.pop_desc     (pop_desc),
		.pop          (pop),
		.phase        (phase)
	);

endmodule

FILE: tb/tb_i2c_master_bit_sequencer.sv
// self-checking testbench for the i2c master bit sequencer
// depends on i2cbs_pkg, the request and line phase interfaces and the rtl top level
module tb_i2c_master_bit_sequencer;
	import i2cbs_pkg::*;

	localparam int STALL_LIMIT    = 6000; // cycles with no handshake before giving up
	localparam int IDLE_PERCENT   = 19;
	localparam int RANDOM_TARGET  = 290;  // requests in the randomised sequences
	localparam int HOLD_OFF_LEN   = 300;  // cycles the receiver refuses every phase

	// one line phase as it appears on the output channel
	typedef struct packed {
		logic       scl_level;
		logic       sda_driven;
		logic       sda_level;
		logic [7:0] rx_byte;
		logic       last_phase;
	} line_phase_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;

	i2cbs_cmd_if   cmd_bus ();
	i2cbs_phase_if phase_bus ();

	i2c_master_bit_sequencer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd        (cmd_bus.sink),
		.phase      (phase_bus.source)
	);

	// line phases still owed by the block, oldest first
	line_phase_t expected_phases[$];

	logic [7:0]  phase_length_copy;   // our copy of the register, timing only
	int          failures;
	int          requests_sent;
	int unsigned rx_hold_left;        // receiver hold-off, counted down by the receiver
	bit          tx_calm;             // sender never idles while set
	bit          rx_calm;             // receiver never idles while set
	int          stall_cycles;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// prediction: the line phases that one request turns into
	// ------------------------------------------------------------------

	function automatic void push_phase(logic scl, logic drv, logic sda, logic [7:0] rx,
		logic last);
		line_phase_t p;
		p.scl_level  = scl;
		p.sda_driven = drv;
		p.sda_level  = sda;
		p.rx_byte    = rx;
		p.last_phase = last;
		expected_phases.push_back(p);
	endfunction

	function automatic void expand_request(logic [1:0] func, logic [7:0] tx_byte,
		logic send_nack, logic [7:0] bus_levels);
		logic [7:0] rx_acc;
		rx_acc = 8'h00;
		case (func)
			CMD_START: begin
				// sda falls while scl is high, then scl is pulled low
				push_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0);
				push_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
				push_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b1);
			end
			CMD_WRITE: begin
				// msb first, data set up with scl low and clocked with scl high
				for (int i = 7; i >= 0; i--) begin
					push_phase(1'b0, 1'b1, tx_byte[i], 8'h00, 1'b0);
					push_phase(1'b1, 1'b1, tx_byte[i], 8'h00, 1'b0);
				end
				// slave ack slot is clocked with sda released but never looked at
				push_phase(1'b0, 1'b0, 1'b1, 8'h00, 1'b0);
				push_phase(1'b1, 1'b0, 1'b1, 8'h00, 1'b0);
				push_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b1);
			end
			CMD_READ: begin
				// sda released for all eight bits, released level reads high
				for (int i = 7; i >= 0; i--) begin
					push_phase(1'b0, 1'b0, 1'b1, 8'h00, 1'b0);
					push_phase(1'b1, 1'b0, 1'b1, 8'h00, 1'b0);
					rx_acc = {rx_acc[6:0], bus_levels[i]};
				end
				push_phase(1'b0, 1'b1, send_nack, 8'h00, 1'b0);
				push_phase(1'b1, 1'b1, send_nack, 8'h00, 1'b0);
				// received byte only shows on the closing phase
				push_phase(1'b0, 1'b1, 1'b1, rx_acc, 1'b1);
			end
			CMD_STOP: begin
				// first phase given as scl low, sda rises by release at the end
				push_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
				push_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
				push_phase(1'b1, 1'b0, 1'b1, 8'h00, 1'b1);
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// line phase receiver: random idling, long hold-off on request
	// ------------------------------------------------------------------

	initial phase_bus.ready = 1'b0;

	always @(negedge clk) begin
		if (!arst_n) begin
			phase_bus.ready <= 1'b0;
		end else if (rx_hold_left != 0) begin
			phase_bus.ready <= 1'b0;
			rx_hold_left = rx_hold_left - 1;
		end else begin
			phase_bus.ready <= rx_calm || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// ------------------------------------------------------------------
	// checker: every accepted phase against the oldest prediction
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		line_phase_t got;
		line_phase_t want;
		if (arst_n && phase_bus.valid && phase_bus.ready) begin
			got.scl_level  = phase_bus.scl_level;
			got.sda_driven = phase_bus.sda_driven;
			got.sda_level  = phase_bus.sda_level;
			got.rx_byte    = phase_bus.rx_byte;
			got.last_phase = phase_bus.last_phase;
			if (expected_phases.size() == 0) begin
				$error("line phase with nothing expected: %p", got);
				failures++;
			end else begin
				want = expected_phases.pop_front();
				if (got.scl_level !== want.scl_level) begin
					$error("scl_level: expected %0d, actual %0d", want.scl_level, got.scl_level);
					failures++;
				end
				if (got.sda_driven !== want.sda_driven) begin
					$error("sda_driven: expected %0d, actual %0d", want.sda_driven,
						got.sda_driven);
					failures++;
				end
				if (got.sda_level !== want.sda_level) begin
					$error("sda_level: expected %0d, actual %0d", want.sda_level, got.sda_level);
					failures++;
				end
				if (got.rx_byte !== want.rx_byte) begin
					$error("rx_byte: expected %02h, actual %02h", want.rx_byte, got.rx_byte);
					failures++;
				end
				if (got.last_phase !== want.last_phase) begin
					$error("last_phase: expected %0d, actual %0d", want.last_phase,
						got.last_phase);
					failures++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: too long without any handshake means the block is stuck
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_bus.valid && cmd_bus.ready) || (phase_bus.valid && phase_bus.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// shared sender tasks; each returns in the time step of a rising edge
	// ------------------------------------------------------------------

	// offer one request, random idle cycles first, and predict it once taken
	task automatic send_request(logic [1:0] func, logic [7:0] tx_byte, logic send_nack,
		logic [7:0] bus_levels);
		@(negedge clk);
		while (!tx_calm && $urandom_range(99) < IDLE_PERCENT) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.valid      <= 1'b1;
		cmd_bus.func       <= func;
		cmd_bus.tx_byte    <= tx_byte;
		cmd_bus.send_nack  <= send_nack;
		cmd_bus.bus_levels <= bus_levels;
		do
			@(posedge clk);
		while (!cmd_bus.ready);
		expand_request(func, tx_byte, send_nack, bus_levels);
		requests_sent++;
	endtask

	// same request with every payload field random, unused ones included
	task automatic send_random_fields(logic [1:0] func);
		send_request(func, 8'($urandom_range(255)), 1'($urandom_range(1)),
			8'($urandom_range(255)));
	endtask

	// stop offering and wait until every predicted phase has come out
	task automatic drain_phases();
		int settle;
		@(negedge clk);
		cmd_bus.valid <= 1'b0;
		while (expected_phases.size() != 0)
			@(posedge clk);
		// back end may still be finishing its closing tick
		settle = (phase_length_copy == 8'd0) ? 5 : int'(phase_length_copy) + 4;
		repeat (settle) @(posedge clk);
	endtask

	// register write, only ever with the block drained
	task automatic set_phase_length(logic [7:0] value);
		drain_phases();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		phase_length_copy = value;
		@(posedge clk);
	endtask

	// well-formed transaction with random content, sometimes noise or broken
	task automatic send_random_transaction();
		int n_bytes;
		if ($urandom_range(99) < 12) begin
			// lone request of any kind
			send_random_fields(2'($urandom_range(3)));
		end else begin
			send_random_fields(CMD_START);
			send_random_fields(CMD_WRITE); // address byte
			n_bytes = $urandom_range(1, 4);
			repeat (n_bytes) begin
				if ($urandom_range(99) < 10)
					send_random_fields(CMD_START); // repeated start
				send_random_fields($urandom_range(1) ? CMD_WRITE : CMD_READ);
			end
			// now and then the stop is left out
			if ($urandom_range(99) < 85)
				send_random_fields(CMD_STOP);
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// every command and field extreme at the reset phase length
	task automatic test_directed_commands();
		send_request(CMD_START, 8'h00, 1'b0, 8'h00);
		send_request(CMD_WRITE, 8'h00, 1'b0, 8'h00);
		send_request(CMD_WRITE, 8'hFF, 1'b1, 8'hFF);   // unused nack and levels set
		send_request(CMD_WRITE, 8'hA5, 1'b0, 8'h5A);
		send_request(CMD_READ,  8'h00, 1'b0, 8'h00);   // ack, all zero
		send_request(CMD_READ,  8'hFF, 1'b1, 8'hFF);   // nack, all ones
		send_request(CMD_READ,  8'h3C, 1'b0, 8'h5A);
		send_request(CMD_STOP,  8'hFF, 1'b1, 8'hFF);   // stop ignores its payload
		send_request(CMD_START, 8'hFF, 1'b1, 8'hFF);   // start ignores its payload
		send_request(CMD_STOP,  8'h00, 1'b0, 8'h00);
		send_request(CMD_STOP,  8'h00, 1'b0, 8'h00);   // stop straight after stop
		send_request(CMD_READ,  8'hC3, 1'b1, 8'h81);
		drain_phases();
	endtask

	// shortest, zero and longest phase length
	task automatic test_phase_length_extremes();
		set_phase_length(8'd1);
		send_request(CMD_START, 8'h12, 1'b0, 8'h34);
		send_request(CMD_WRITE, 8'h3C, 1'b0, 8'h00);
		send_request(CMD_STOP,  8'h00, 1'b0, 8'h00);
		// zero is stored as written and paces the phases as a phase length of one does
		set_phase_length(8'd0);
		send_request(CMD_READ,  8'h00, 1'b0, 8'hC3);
		send_request(CMD_WRITE, 8'h81, 1'b1, 8'h00);
		set_phase_length(8'd255);
		send_request(CMD_START, 8'h00, 1'b0, 8'h00);
		send_request(CMD_WRITE, 8'h81, 1'b0, 8'h00);
		send_request(CMD_READ,  8'h00, 1'b1, 8'h7E);
		send_request(CMD_STOP,  8'h00, 1'b0, 8'h00);
		set_phase_length(8'd7);
	endtask

	// randomised transactions over several phase lengths
	task automatic test_random_sequences();
		int stop_at;
		int next_cfg;
		stop_at  = requests_sent + RANDOM_TARGET;
		next_cfg = requests_sent + 40;
		while (requests_sent < stop_at) begin
			if (requests_sent >= next_cfg) begin
				case ($urandom_range(7))
					0:       set_phase_length(8'd0);
					1:       set_phase_length(8'd1);
					default: set_phase_length(8'($urandom_range(2, 16)));
				endcase
				next_cfg = requests_sent + 40;
			end
			send_random_transaction();
		end
		drain_phases();
	endtask

	// receiver holds off so the request queue fills and the input stalls
	task automatic test_receiver_hold_off();
		set_phase_length(8'd2);
		rx_hold_left = HOLD_OFF_LEN;
		repeat (8) send_random_fields(2'($urandom_range(3)));
		// sender waits until the block has emptied before carrying on
		drain_phases();
	endtask

	// back to back requests with both sides always ready
	task automatic test_no_idling();
		int stop_at;
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		stop_at = requests_sent + 30;
		while (requests_sent < stop_at)
			send_random_transaction();
		drain_phases();
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	initial begin
		int tail;
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_wr_data        = 8'h00;
		cmd_bus.valid      = 1'b0;
		cmd_bus.func       = CMD_START;
		cmd_bus.tx_byte    = 8'h00;
		cmd_bus.send_nack  = 1'b0;
		cmd_bus.bus_levels = 8'h00;
		phase_length_copy  = PHASE_LENGTH_RST;
		failures           = 0;
		requests_sent      = 0;
		rx_hold_left       = 0;
		tx_calm            = 1'b0;
		rx_calm            = 1'b0;
		stall_cycles       = 0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_commands();
		test_phase_length_extremes();
		test_receiver_hold_off();
		test_no_idling();
		test_random_sequences();

		// all requests taken: wait out the owed phases, then watch for strays
		drain_phases();
		tail = 3 * ((phase_length_copy == 8'd0) ? 1 : int'(phase_length_copy)) + 20;
		repeat (tail) @(posedge clk);
		if (expected_phases.size() != 0) begin
			$error("%0d line phases never came out", expected_phases.size());
			failures++;
		end

		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
